// ===== hw/rtl/csg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csg_pkg: shared constants and types for the cell star generator
// Hash constants, fixed-point constants, register map, control/status bundles.
// ----------------------------------------------------------------------------
package csg_pkg;

    // FNV-1a and avalanche
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] AVAL_MUL  = 32'h7feb352d;
    localparam logic [31:0] SEED_ONE  = 32'h0000_0001;

    // star count
    localparam int MAX_STARS = 16;
    localparam int CNT_W     = $clog2(MAX_STARS + 1);
    localparam int RAW_W     = 5;   // floor(density) + 1 never exceeds 16

    // brightness: lbf * (3*2^24 + 2d) / (5*2^24)
    localparam logic [26:0] BRIGHT_BASE = 27'd50331648;
    // floor(x/5) = (x * 838861) >> 22 for x < 2^20
    localparam logic [19:0] DIV5_MUL    = 20'd838861;
    localparam logic [16:0] BRIGHT_MAX  = 17'd65536;
    localparam logic [8:0]  FADE_FULL   = 9'd256;

    // register map, index = paddr[3:2]
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_CELL_SIZE   = 2'd0;
    localparam logic [1:0] REG_PIXEL_SCALE = 2'd1;
    localparam logic [1:0] REG_ZOOM_FADE   = 2'd2;

    localparam logic [15:0] CELL_SIZE_RST   = 16'd256;
    localparam logic [11:0] PIXEL_SCALE_RST = 12'd256;
    localparam logic [8:0]  ZOOM_FADE_RST   = 9'd256;

    typedef struct packed {
        logic [15:0] cell_size;
        logic [11:0] pixel_scale;
        logic [8:0]  zoom_fade;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic hash1;
        logic hash2;
        logic hash3;
        logic hash4;
        logic count;
        logic sx;
        logic sy;
        logic ss;
        logic sb;
        logic st;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic fade_zero;
        logic count_zero;
        logic last_star;
        logic out_free;
    } t_status;

    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] a;
        logic [31:0] b;
        a = s ^ (s << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

endpackage

// ===== hw/rtl/csg_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csg_ifs: stream interfaces of the cell star generator
// Cell request channel and star result channel, valid/ready.
// ----------------------------------------------------------------------------
interface csg_cell_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic [1:0]         layer_index;
    logic [11:0]        density;
    logic [11:0]        size_low;
    logic [11:0]        size_high;
    logic [8:0]         layer_brightness;

    modport source (
        output valid, cell_x, cell_y, layer_index, density, size_low, size_high,
               layer_brightness,
        input  ready
    );
    modport sink (
        input  valid, cell_x, cell_y, layer_index, density, size_low, size_high,
               layer_brightness,
        output ready
    );
endinterface

interface csg_star_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        star_size;
    logic [16:0]        star_bright;
    logic [7:0]         tint;
    logic               last;

    modport source (
        output valid, pos_x, pos_y, star_size, star_bright, tint, last,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, star_size, star_bright, tint, last,
        output ready
    );
endinterface

// ===== hw/rtl/csg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csg_regs: configuration registers
// APB-style write/read of cell_size, pixel_scale and zoom_fade.
// ----------------------------------------------------------------------------
module csg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [csg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output csg_pkg::t_cfg              o_cfg
);

    csg_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_size   <= csg_pkg::CELL_SIZE_RST;
            r_cfg.pixel_scale <= csg_pkg::PIXEL_SCALE_RST;
            r_cfg.zoom_fade   <= csg_pkg::ZOOM_FADE_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                csg_pkg::REG_CELL_SIZE:   r_cfg.cell_size   <= pwdata[15:0];
                csg_pkg::REG_PIXEL_SCALE: r_cfg.pixel_scale <= pwdata[11:0];
                csg_pkg::REG_ZOOM_FADE:   r_cfg.zoom_fade   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            csg_pkg::REG_CELL_SIZE:   prdata = {16'd0, r_cfg.cell_size};
            csg_pkg::REG_PIXEL_SCALE: prdata = {20'd0, r_cfg.pixel_scale};
            csg_pkg::REG_ZOOM_FADE:   prdata = {23'd0, r_cfg.zoom_fade};
            default:                  prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/csg_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csg_datapath: hash, xorshift generator and star arithmetic
// One shared 32-bit hash multiplier, one draw per step, output register.
// ----------------------------------------------------------------------------
module csg_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csg_pkg::t_cfg       i_cfg,
    input  csg_pkg::t_cmd       i_cmd,
    output csg_pkg::t_status    o_status,
    // cell fields, sampled on load
    input  logic signed [15:0]  i_cell_x,
    input  logic signed [15:0]  i_cell_y,
    input  logic [1:0]          i_layer_index,
    input  logic [11:0]         i_density,
    input  logic [11:0]         i_size_low,
    input  logic [11:0]         i_size_high,
    input  logic [8:0]          i_layer_brightness,
    // star output
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic [15:0]         o_star_size,
    output logic [16:0]         o_star_bright,
    output logic [7:0]          o_tint,
    output logic                o_last
);

    localparam int CW = csg_pkg::CNT_W;

    // captured cell
    logic [15:0] r_cx;
    logic [15:0] r_cy;
    logic [1:0]  r_layer;
    logic [11:0] r_dens;
    logic [11:0] r_slo;
    logic [11:0] r_shi;
    logic [16:0] r_lbf;     // brightness * fade

    logic [31:0] r_h;
    logic [31:0] r_rng;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_k;

    // per-star pipeline
    logic [31:0]        r_phi;      // cell * cell_size, low 32 bits
    logic [39:0]        r_plo;      // draw * cell_size
    logic [31:0]        r_pos_x;
    logic [31:0]        r_pos_y;
    logic signed [37:0] r_szm;      // draw * (size_high - size_low)
    logic [35:0]        r_inner;
    logic [47:0]        r_szp;
    logic [43:0]        r_brm;
    logic [39:0]        r_q;
    logic [7:0]         r_tint;

    // output register
    logic               r_out_valid;
    logic [31:0]        r_o_pos_x;
    logic [31:0]        r_o_pos_y;
    logic [15:0]        r_o_size;
    logic [16:0]        r_o_bright;
    logic [7:0]         r_o_tint;
    logic               r_o_last;

    logic [8:0]          w_fade;
    logic [31:0]         w_hmul_k;
    logic [31:0]         w_hprod;
    logic [31:0]         w_aval;
    logic [31:0]         w_rng_next;
    logic [23:0]         w_draw;
    logic                w_frac_hit;
    logic [csg_pkg::RAW_W-1:0] w_cnt_raw;
    logic [CW-1:0]       w_cnt;
    logic [31:0]         w_cell32;
    logic signed [24:0]  w_ds;
    logic signed [12:0]  w_diff;
    logic [26:0]         w_bmul;
    logic [17:0]         w_q;
    logic [16:0]         w_bright;
    logic [31:0]         w_pos_sum;

    assign w_fade = (i_cfg.zoom_fade > csg_pkg::FADE_FULL) ? csg_pkg::FADE_FULL
                                                           : i_cfg.zoom_fade;

    // hash multiplier, shared by all hash steps
    assign w_hmul_k = i_cmd.hash4 ? csg_pkg::AVAL_MUL : csg_pkg::FNV_PRIME;
    assign w_hprod  = r_h * w_hmul_k;
    assign w_aval   = w_hprod ^ (w_hprod >> 15);

    assign w_rng_next = csg_pkg::xorshift32(r_rng);
    assign w_draw     = w_rng_next[31:8];

    assign w_frac_hit = (w_draw < {r_dens[7:0], 16'd0});
    assign w_cnt_raw  = csg_pkg::RAW_W'(r_dens[11:8]) + csg_pkg::RAW_W'(w_frac_hit);
    assign w_cnt      = (w_cnt_raw > csg_pkg::RAW_W'(csg_pkg::MAX_STARS))
                        ? CW'(csg_pkg::MAX_STARS) : CW'(w_cnt_raw);

    assign w_cell32  = i_cmd.sy ? {{16{r_cy[15]}}, r_cy} : {{16{r_cx[15]}}, r_cx};
    assign w_pos_sum = r_phi + {16'd0, r_plo[39:24]};

    assign w_ds   = $signed({1'b0, w_draw});
    assign w_diff = $signed({1'b0, r_shi}) - $signed({1'b0, r_slo});
    assign w_bmul = csg_pkg::BRIGHT_BASE + {2'b00, w_draw, 1'b0};

    assign w_q      = r_q[39:22];
    assign w_bright = (w_q > {1'b0, csg_pkg::BRIGHT_MAX}) ? csg_pkg::BRIGHT_MAX
                                                         : w_q[16:0];

    // cell capture and hash
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx    <= i_cell_x;
            r_cy    <= i_cell_y;
            r_layer <= i_layer_index;
            r_dens  <= i_density;
            r_slo   <= i_size_low;
            r_shi   <= i_size_high;
            r_lbf   <= {8'd0, i_layer_brightness} * {8'd0, w_fade};
            r_h     <= csg_pkg::FNV_BASIS ^ {{16{i_cell_x[15]}}, i_cell_x};
        end else if (i_cmd.hash1) begin
            r_h <= w_hprod ^ {{16{r_cy[15]}}, r_cy};
        end else if (i_cmd.hash2) begin
            r_h <= w_hprod ^ {30'd0, r_layer};
        end else if (i_cmd.hash3) begin
            r_h <= w_hprod ^ (w_hprod >> 16);
        end
    end

    // generator state: seeded at the avalanche step, stepped once per draw
    always_ff @(posedge i_clk) begin
        if (i_cmd.hash4) begin
            r_rng <= (w_aval == 32'd0) ? csg_pkg::SEED_ONE : w_aval;
        end else if (i_cmd.count | i_cmd.sx | i_cmd.sy | i_cmd.ss | i_cmd.sb
                     | i_cmd.st) begin
            r_rng <= w_rng_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_k     <= '0;
        end else if (i_cmd.count) begin
            r_count <= w_cnt;
            r_k     <= '0;
        end else if (i_cmd.emit) begin
            r_k <= r_k + CW'(1);
        end
    end

    // star arithmetic, one stage per draw
    always_ff @(posedge i_clk) begin
        if (i_cmd.sx | i_cmd.sy) begin
            r_phi <= w_cell32 * {16'd0, i_cfg.cell_size};
            r_plo <= {16'd0, w_draw} * {24'd0, i_cfg.cell_size};
        end
        if (i_cmd.sy) begin
            r_pos_x <= w_pos_sum;
        end
        if (i_cmd.ss) begin
            r_pos_y <= w_pos_sum;
            r_szm   <= w_ds * w_diff;
        end
        if (i_cmd.sb) begin
            r_inner <= {r_slo, 24'd0} + r_szm[35:0];
            r_brm   <= {27'd0, r_lbf} * {17'd0, w_bmul};
        end
        if (i_cmd.st) begin
            r_tint <= w_draw[23:16];
            r_szp  <= {12'd0, r_inner} * {36'd0, i_cfg.pixel_scale};
            r_q    <= {20'd0, r_brm[43:24]} * {20'd0, csg_pkg::DIV5_MUL};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_pos_x  <= r_pos_x;
            r_o_pos_y  <= r_pos_y;
            r_o_size   <= r_szp[47:32];
            r_o_bright <= w_bright;
            r_o_tint   <= r_tint;
            r_o_last   <= o_status.last_star;
        end
    end

    assign o_status.fade_zero  = (i_cfg.zoom_fade == 9'd0);
    assign o_status.count_zero = (w_cnt == '0);
    assign o_status.last_star  = (r_k == r_count - CW'(1));
    assign o_status.out_free   = ~r_out_valid | i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = $signed(r_o_pos_x);
    assign o_pos_y       = $signed(r_o_pos_y);
    assign o_star_size   = r_o_size;
    assign o_star_bright = r_o_bright;
    assign o_tint        = r_o_tint;
    assign o_last        = r_o_last;

`ifndef ASSERT_OFF
    a_seed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hash4 |=> r_rng != 32'd0)
        else $error("generator seeded with zero");

    a_star_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sx |-> r_k < r_count)
        else $error("star index past star count");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.count |=> r_count <= CW'(csg_pkg::MAX_STARS))
        else $error("star count above cap");
`endif

endmodule

// ===== hw/rtl/csg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csg_ctrl: sequencer of the cell star generator
// Steps the hash, the count draw and five draws plus emit per star.
// ----------------------------------------------------------------------------
module csg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  csg_pkg::t_status i_status,
    output csg_pkg::t_cmd    o_cmd
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_HASH1 = 12'b0000_0000_0010,
        ST_HASH2 = 12'b0000_0000_0100,
        ST_HASH3 = 12'b0000_0000_1000,
        ST_HASH4 = 12'b0000_0001_0000,
        ST_COUNT = 12'b0000_0010_0000,
        ST_SX    = 12'b0000_0100_0000,
        ST_SY    = 12'b0000_1000_0000,
        ST_SS    = 12'b0001_0000_0000,
        ST_SB    = 12'b0010_0000_0000,
        ST_ST    = 12'b0100_0000_0000,
        ST_EMIT  = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid & o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && !i_status.fade_zero) n_state = ST_HASH1;
            end
            ST_HASH1: n_state = ST_HASH2;
            ST_HASH2: n_state = ST_HASH3;
            ST_HASH3: n_state = ST_HASH4;
            ST_HASH4: n_state = ST_COUNT;
            ST_COUNT: begin
                n_state = i_status.count_zero ? ST_IDLE : ST_SX;
            end
            ST_SX: n_state = ST_SY;
            ST_SY: n_state = ST_SS;
            ST_SS: n_state = ST_SB;
            ST_SB: n_state = ST_ST;
            ST_ST: n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.last_star ? ST_IDLE : ST_SX;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.load  = w_accept;
    assign o_cmd.hash1 = (r_state == ST_HASH1);
    assign o_cmd.hash2 = (r_state == ST_HASH2);
    assign o_cmd.hash3 = (r_state == ST_HASH3);
    assign o_cmd.hash4 = (r_state == ST_HASH4);
    assign o_cmd.count = (r_state == ST_COUNT);
    assign o_cmd.sx    = (r_state == ST_SX);
    assign o_cmd.sy    = (r_state == ST_SY);
    assign o_cmd.ss    = (r_state == ST_SS);
    assign o_cmd.sb    = (r_state == ST_SB);
    assign o_cmd.st    = (r_state == ST_ST);
    assign o_cmd.emit  = (r_state == ST_EMIT) & i_status.out_free;

`ifndef ASSERT_OFF
    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !i_status.out_free) |=> r_state == ST_EMIT)
        else $error("star left before output register was free");
`endif

endmodule

// ===== hw/rtl/cell_star_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_star_generator: procedural stars of one grid cell
// Top level: config registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Each cell transfer (cell_x, cell_y, layer_index plus the layer's density,
// size range and brightness) is hashed with FNV-1a and an avalanche step; the
// hash seeds a xorshift32 generator (1 when the hash is 0). The first draw
// decides whether the fractional density adds a star, then every star uses
// five draws (x, y, size, brightness, tint) and leaves as one transfer on
// o_star, with last set on the cell's final star. Cells with no stars, and
// every cell while zoom_fade is 0, produce no output transfer. Timing: after
// the cell transfer the block steps through the hash states and the count
// draw, then through one state per draw and an emit state per star (n
// stars, at most 16). A star waits in its emit state while the single-entry
// output register is still full; the next cell is taken only after the last
// star has entered it. While zoom_fade is 0 a cell is dropped at once and
// the next one is taken on the following cycle. The steps follow from the
// one-draw-per-cycle generator and the shared 32-bit hash multiplier.
// Registers (APB, write in the access phase, pready always high):
// 0x0 cell_size (Q8.8), 0x4 pixel_scale (Q4.8), 0x8 zoom_fade (Q1.8,
// values above 256 act as 256). Write them only while no cell is in flight.
// ----------------------------------------------------------------------------
module cell_star_generator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    csg_cell_if.sink                   i_cell,
    csg_star_if.source                 o_star,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [csg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    csg_pkg::t_cfg    w_cfg;
    csg_pkg::t_cmd    w_cmd;
    csg_pkg::t_status w_status;
    logic             w_in_ready;

    csg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer: one state per hash step, per draw and for the emit
    csg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cell.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    assign i_cell.ready = w_in_ready;

    // datapath: hash, generator, star math and the output register
    csg_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (w_cfg),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_cell_x           (i_cell.cell_x),
        .i_cell_y           (i_cell.cell_y),
        .i_layer_index      (i_cell.layer_index),
        .i_density          (i_cell.density),
        .i_size_low         (i_cell.size_low),
        .i_size_high        (i_cell.size_high),
        .i_layer_brightness (i_cell.layer_brightness),
        .i_out_ready        (o_star.ready),
        .o_out_valid        (o_star.valid),
        .o_pos_x            (o_star.pos_x),
        .o_pos_y            (o_star.pos_y),
        .o_star_size        (o_star.star_size),
        .o_star_bright      (o_star.star_bright),
        .o_tint             (o_star.tint),
        .o_last             (o_star.last)
    );

endmodule

// ===== dv/cell_star_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_star_generator_tb: self-checking bench for the cell star generator
// A directed table of cells and register writes runs first, then random cells
// over a series of register settings. Every star is predicted from the cell
// hash and the xorshift draws and compared field by field, in order.
// ----------------------------------------------------------------------------
module cell_star_generator_tb;

    localparam int HALF_PERIOD  = 6;
    localparam int RANDOM_CELLS = 240;
    localparam int SETTLE       = 40;     // a star-less cell may still be in flight
    localparam int DRAIN_LIMIT  = 5000;
    localparam int LONG_HOLD    = 400;
    localparam int SHOW_LIMIT   = 10;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [1:0]         layer;
        logic [11:0]        dens;
        logic [11:0]        slo;
        logic [11:0]        shi;
        logic [8:0]         lb;
    } t_cell_req;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        star_size;
        logic [16:0]        star_bright;
        logic [7:0]         tint;
        logic               last;
    } t_star;

    typedef enum logic {ROW_CELL, ROW_REG} t_row_kind;

    // one line of the directed plan; no_stars marks cells whose answer is
    // plainly "nothing" (zero density, zero fade)
    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic [31:0] value;
        t_cell_req   req;
        logic        no_stars;
    } t_row;

    localparam int PLAN_ROWS = 29;
    localparam t_row PLAN [PLAN_ROWS] = '{
        // zero density: no star, no transfer
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'h0000, 16'h0000, 2'd0, 12'h000, 12'd0, 12'd4095, 9'd256}, 1'b1},
        // whole density, no fraction
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'h0000, 16'h0000, 2'd0, 12'h100, 12'd0, 12'd4095, 9'd256}, 1'b0},
        // most stars, reversed size range, brightness above range
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'hFFFF, 16'hFFFF, 2'd3, 12'hFFF, 12'd4095, 12'd0, 9'd511}, 1'b0},
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'h7FFF, 16'h7FFF, 2'd1, 12'h0FF, 12'd4095, 12'd4095, 9'd0}, 1'b0},
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'h8000, 16'h8000, 2'd2, 12'h180, 12'd0, 12'd0, 9'd256}, 1'b0},
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'h7FFF, 16'h8000, 2'd3, 12'h201, 12'd100, 12'd200, 9'd128}, 1'b0},
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'h5555, 16'hAAAA, 2'd1, 12'hAAA, 12'hAAA, 12'h555, 9'h155}, 1'b0},
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'hAAAA, 16'h5555, 2'd2, 12'h555, 12'h555, 12'hAAA, 9'h0AA}, 1'b0},
        // zero cell size: every position collapses to 0
        '{ROW_REG, csg_pkg::REG_CELL_SIZE, 32'd0, '0, 1'b0},
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'h0005, 16'hFFFB, 2'd0, 12'h300, 12'd10, 12'd20, 9'd256}, 1'b0},
        // largest scales, fade above full acts as full
        '{ROW_REG, csg_pkg::REG_CELL_SIZE, 32'd65535, '0, 1'b0},
        '{ROW_REG, csg_pkg::REG_PIXEL_SCALE, 32'd4095, '0, 1'b0},
        '{ROW_REG, csg_pkg::REG_ZOOM_FADE, 32'd511, '0, 1'b0},
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'h8000, 16'h7FFF, 2'd3, 12'hF00, 12'd0, 12'd4095, 9'd511}, 1'b0},
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'h7FFF, 16'h8000, 2'd0, 12'h4FF, 12'd4095, 12'd4095, 9'd256}, 1'b0},
        // zero fade: cells are swallowed whatever their density
        '{ROW_REG, csg_pkg::REG_ZOOM_FADE, 32'd0, '0, 1'b0},
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'h0000, 16'h0000, 2'd0, 12'hFFF, 12'd0, 12'd4095, 9'd256}, 1'b1},
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'h1234, 16'hFFFD, 2'd1, 12'h100, 12'd0, 12'd4095, 9'd256}, 1'b1},
        // smallest nonzero cell size and fade, zero pixel scale
        '{ROW_REG, csg_pkg::REG_CELL_SIZE, 32'd1, '0, 1'b0},
        '{ROW_REG, csg_pkg::REG_PIXEL_SCALE, 32'd0, '0, 1'b0},
        '{ROW_REG, csg_pkg::REG_ZOOM_FADE, 32'd1, '0, 1'b0},
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'hFFFE, 16'h0003, 2'd2, 12'h2C0, 12'd0, 12'd4095, 9'd511}, 1'b0},
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'h7FFF, 16'h7FFF, 2'd3, 12'h3FF, 12'd4095, 12'd0, 9'd256}, 1'b0},
        '{ROW_REG, csg_pkg::REG_ZOOM_FADE, 32'd257, '0, 1'b0},
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'h0001, 16'h0001, 2'd1, 12'h280, 12'd50, 12'd3000, 9'd256}, 1'b0},
        // back to the reset settings
        '{ROW_REG, csg_pkg::REG_CELL_SIZE, 32'd256, '0, 1'b0},
        '{ROW_REG, csg_pkg::REG_PIXEL_SCALE, 32'd256, '0, 1'b0},
        '{ROW_REG, csg_pkg::REG_ZOOM_FADE, 32'd256, '0, 1'b0},
        '{ROW_CELL, csg_pkg::REG_CELL_SIZE, 32'd0,
          '{16'h0003, 16'h0004, 2'd0, 12'h100, 12'd256, 12'd512, 9'd256}, 1'b0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [csg_pkg::ADDR_W-1:0] paddr   = '0;
    logic [31:0]                pwdata  = '0;
    logic [31:0]                prdata;
    logic                       pready;

    csg_cell_if cell_bus ();
    csg_star_if star_bus ();

    cell_star_generator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_bus),
        .o_star  (star_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // shadow copy of the register file, kept in step by set_reg
    logic [15:0] cfg_cell_size   = csg_pkg::CELL_SIZE_RST;
    logic [11:0] cfg_pixel_scale = csg_pkg::PIXEL_SCALE_RST;
    logic [8:0]  cfg_zoom_fade   = csg_pkg::ZOOM_FADE_RST;

    t_star stars_due [$];        // predicted stars, oldest first
    int    errors      = 0;
    int    stars_seen  = 0;
    bit    random_part = 1'b0;

    function automatic void note_fail(input string msg);
        errors++;
        if (errors <= SHOW_LIMIT)
            $display("%s", msg);
    endfunction

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rng_next(input logic [31:0] s);
        logic [31:0] v;
        v = s;
        v = v ^ (v << 13);
        v = v ^ (v >> 17);
        v = v ^ (v << 5);
        return v;
    endfunction

    // Hash the cell, seed the generator, decide the star count from the
    // first draw, then five draws per star: x, y, size, brightness, tint.
    function automatic void cell_stars(input t_cell_req c);
        logic [31:0]     h;
        logic [31:0]     rng;
        logic [31:0]     d;
        logic [8:0]      fade;
        int              n;
        longint          t;
        longint          sz;
        longint unsigned br;
        t_star           s;
        fade = (cfg_zoom_fade > csg_pkg::FADE_FULL) ? csg_pkg::FADE_FULL : cfg_zoom_fade;
        if (fade == 0)
            return;
        h = csg_pkg::FNV_BASIS;
        h = (h ^ {{16{c.cx[15]}}, c.cx}) * csg_pkg::FNV_PRIME;
        h = (h ^ {{16{c.cy[15]}}, c.cy}) * csg_pkg::FNV_PRIME;
        h = (h ^ {30'd0, c.layer}) * csg_pkg::FNV_PRIME;
        h = h ^ (h >> 16);
        h = h * csg_pkg::AVAL_MUL;
        h = h ^ (h >> 15);
        rng = (h == 32'd0) ? 32'd1 : h;

        rng = rng_next(rng);
        d   = rng >> 8;
        n   = int'(c.dens[11:8]);
        if (d < {8'd0, c.dens[7:0], 16'd0})
            n++;
        if (n > csg_pkg::MAX_STARS)
            n = csg_pkg::MAX_STARS;

        for (int k = 0; k < n; k++) begin
            rng = rng_next(rng);
            d   = rng >> 8;
            t   = (longint'(c.cx) * 64'sd16777216 + longint'(d)) * longint'(cfg_cell_size);
            s.pos_x = 32'(t >>> 24);

            rng = rng_next(rng);
            d   = rng >> 8;
            t   = (longint'(c.cy) * 64'sd16777216 + longint'(d)) * longint'(cfg_cell_size);
            s.pos_y = 32'(t >>> 24);

            rng = rng_next(rng);
            d   = rng >> 8;
            t   = (longint'(c.slo) * 64'sd16777216
                   + longint'(d) * (longint'(c.shi) - longint'(c.slo)))
                  * longint'(cfg_pixel_scale);
            sz  = t >>> 32;
            if (sz < 0)
                sz = 0;
            if (sz > 65535)
                sz = 65535;
            s.star_size = 16'(sz);

            rng = rng_next(rng);
            d   = rng >> 8;
            br  = longint'(c.lb) * longint'(fade) * (64'd50331648 + 2 * longint'(d));
            br  = br / 64'd83886080;
            if (br > 65536)
                br = 65536;
            s.star_bright = 17'(br);

            rng = rng_next(rng);
            d   = rng >> 8;
            s.tint = d[23:16];
            s.last = (k == n - 1);
            stars_due = {stars_due, s};
        end
    endfunction

    function automatic t_cell_req rand_cell();
        t_cell_req c;
        int        r;
        r = $urandom_range(0, 9);
        c.cx = (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF : 16'($urandom);
        r = $urandom_range(0, 9);
        c.cy = (r == 0) ? 16'h8000 : (r == 1) ? 16'hFFFF : 16'($urandom);
        c.layer = 2'($urandom);
        // keep the average star count low, with the full range now and then
        r = $urandom_range(0, 99);
        if (r < 80)
            c.dens = 12'($urandom_range(0, 12'h3FF));
        else if (r < 95)
            c.dens = 12'($urandom);
        else
            c.dens = ($urandom_range(0, 1) == 0) ? 12'hFFF : 12'h0FF;
        c.slo = 12'($urandom);
        c.shi = ($urandom_range(0, 9) == 0) ? c.slo : 12'($urandom);
        c.lb  = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(257, 511))
                                            : 9'($urandom_range(0, 256));
        return c;
    endfunction

    // Called on a falling edge; returns on a falling edge. valid stays high
    // when the next cell follows without a gap.
    task automatic put_cell(input t_cell_req c, input bit no_stars, input int gap);
        cell_bus.valid            = 1'b1;
        cell_bus.cell_x           = c.cx;
        cell_bus.cell_y           = c.cy;
        cell_bus.layer_index      = c.layer;
        cell_bus.density          = c.dens;
        cell_bus.size_low         = c.slo;
        cell_bus.size_high        = c.shi;
        cell_bus.layer_brightness = c.lb;
        @(posedge i_clk);
        while (!cell_bus.ready)
            @(posedge i_clk);
        if (!no_stars)
            cell_stars(c);
        @(negedge i_clk);
        if (gap > 0) begin
            cell_bus.valid = 1'b0;
            {cell_bus.cell_x, cell_bus.cell_y} = $urandom;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Stop offering cells and wait for every predicted star, then let a
    // trailing star-less cell finish before anything else happens.
    task automatic drain();
        int waited;
        waited = 0;
        cell_bus.valid = 1'b0;
        while (stars_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (stars_due.size() != 0) begin
            note_fail($sformatf("%0d predicted stars never arrived", stars_due.size()));
            stars_due.delete();
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] kept;
        case (idx)
            csg_pkg::REG_CELL_SIZE: begin
                cfg_cell_size = val[15:0];
                kept = {16'd0, val[15:0]};
            end
            csg_pkg::REG_PIXEL_SCALE: begin
                cfg_pixel_scale = val[11:0];
                kept = {20'd0, val[11:0]};
            end
            csg_pkg::REG_ZOOM_FADE: begin
                cfg_zoom_fade = val[8:0];
                kept = {23'd0, val[8:0]};
            end
            default: begin
                kept = '0;
            end
        endcase
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        pwdata  = $urandom;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata !== kept)
            note_fail($sformatf("register %0d read back %h, wrote %h", idx, prdata, kept));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Star sink: ready is driven on the falling edge. Stall behavior is
    // redrawn at random, periodically, among none, light and heavy. Once, while
    // the sender is busy in the random part, ready is held low long enough
    // for the output register to fill and the cell input to back up.
    // ------------------------------------------------------------------
    initial begin : star_sink
        int stall;
        int mode;
        int since;
        bit held;
        stall = 0;
        mode  = 0;
        since = 0;
        held  = 1'b0;
        star_bus.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (since == 0) begin
                mode  = $urandom_range(0, 2);
                since = 150;
            end
            since--;
            if (!held && random_part && cell_bus.valid && stars_seen > 40) begin
                held  = 1'b1;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                star_bus.ready = 1'b0;
                stall--;
            end else begin
                star_bus.ready = 1'b1;
                if (mode != 0 && $urandom_range(0, 99) < ((mode == 1) ? 10 : 30))
                    stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Star checker: every transfer is matched against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : star_check
        t_star want;
        if (i_rst_n && star_bus.valid && star_bus.ready) begin
            stars_seen++;
            if (stars_due.size() == 0) begin
                note_fail($sformatf("unexpected star x=%0d y=%0d size=%0d br=%0d",
                                    star_bus.pos_x, star_bus.pos_y,
                                    star_bus.star_size, star_bus.star_bright));
            end else begin
                want = stars_due.pop_front();
                if (star_bus.pos_x !== want.pos_x || star_bus.pos_y !== want.pos_y ||
                    star_bus.star_size !== want.star_size ||
                    star_bus.star_bright !== want.star_bright ||
                    star_bus.tint !== want.tint || star_bus.last !== want.last)
                    note_fail($sformatf({"star mismatch: exp x=%0d y=%0d size=%0d br=%0d",
                                         " tint=%0d last=%0b; got x=%0d y=%0d size=%0d",
                                         " br=%0d tint=%0d last=%0b"},
                                        want.pos_x, want.pos_y, want.star_size,
                                        want.star_bright, want.tint, want.last,
                                        star_bus.pos_x, star_bus.pos_y,
                                        star_bus.star_size, star_bus.star_bright,
                                        star_bus.tint, star_bus.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed plan, then random phases. Each phase after
    // the first waits for the block to empty, rewrites all three registers
    // and sends a batch of random cells. Phases with zero fade are short
    // and do not count toward the random cell total.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          counted;
        int          phase;
        int          batch;
        bit          calm;
        logic [15:0] cs;
        logic [11:0] ps;
        logic [8:0]  zf;
        int          r;
        counted = 0;
        phase   = 0;
        cell_bus.valid            = 1'b0;
        cell_bus.cell_x           = '0;
        cell_bus.cell_y           = '0;
        cell_bus.layer_index      = '0;
        cell_bus.density          = '0;
        cell_bus.size_low         = '0;
        cell_bus.size_high        = '0;
        cell_bus.layer_brightness = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int row = 0; row < PLAN_ROWS; row++) begin
            if (PLAN[row].kind == ROW_REG) begin
                drain();
                set_reg(PLAN[row].idx, PLAN[row].value);
            end else begin
                put_cell(PLAN[row].req, PLAN[row].no_stars, pick_gap());
            end
        end

        random_part = 1'b1;
        while (counted < RANDOM_CELLS) begin
            if (phase > 0) begin
                // pausing here also covers the sender waiting for every star
                drain();
                case (phase)
                    1: begin
                        cs = 16'd65535;
                        ps = 12'd4095;
                        zf = 9'($urandom_range(257, 511));
                    end
                    2: begin
                        cs = 16'd1;
                        ps = 12'd0;
                        zf = 9'd1;
                    end
                    3: begin
                        cs = 16'd0;
                        ps = 12'($urandom);
                        zf = 9'd0;
                    end
                    default: begin
                        r  = $urandom_range(0, 4);
                        cs = (r == 0) ? 16'd0 : (r == 1) ? 16'd1 :
                             (r == 2) ? 16'd65535 : 16'($urandom);
                        r  = $urandom_range(0, 3);
                        ps = (r == 0) ? 12'd0 : (r == 1) ? 12'd4095 : 12'($urandom);
                        r  = $urandom_range(0, 9);
                        zf = (r == 0) ? 9'd0 : (r == 1) ? 9'($urandom_range(257, 511)) :
                             (r == 2) ? 9'd1 : 9'($urandom_range(1, 256));
                    end
                endcase
                set_reg(csg_pkg::REG_CELL_SIZE, {16'($urandom), cs});
                set_reg(csg_pkg::REG_PIXEL_SCALE, {20'($urandom), ps});
                set_reg(csg_pkg::REG_ZOOM_FADE, {23'($urandom), zf});
            end
            calm  = (phase % 3 == 2);
            batch = (cfg_zoom_fade == 9'd0) ? 6 : 30;
            for (int i = 0; i < batch; i++) begin
                put_cell(rand_cell(), 1'b0, calm ? 0 : pick_gap());
                if (cfg_zoom_fade != 9'd0)
                    counted++;
            end
            phase++;
        end
        random_part = 1'b0;

        drain();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin : watchdog
        #15_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
